>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Types and constants of the decimating convolution with signal extension.
// ----------------------------------------------------------------------------
package dce_pkg;

    localparam int VALUE_W    = 16;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int MODE_W     = 3;
    localparam int STEP_W     = 2;
    localparam int TAPCNT_W   = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS = 2'd2;

    // Extension modes
    localparam logic [MODE_W-1:0] MODE_ZERO   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SYM    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LINEXT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PER    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PERZ   = 3'd5;

    // Input function codes
    localparam logic FUNC_TAP    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_INIT,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT,
        ST_FINISH
    } t_state;

    // Source of the extended sample for one tap
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_MEM,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_SML,
        SEL_SMR
    } t_ext_sel;

    typedef struct packed {
        logic     valid;
        logic     clr;
        t_ext_sel sel;
    } t_issue;

endpackage

>>> rtl/dce_if.sv
// ----------------------------------------------------------------------------
// dce_in_if / dce_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dce_in_if import dce_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, func, value, last, input ready);
    modport sink   (input valid, func, value, last, output ready);
endinterface

interface dce_out_if import dce_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] coefficient;
    logic                    last_result;

    modport source (output valid, coefficient, last_result, input ready);
    modport sink   (input valid, coefficient, last_result, output ready);
endinterface

>>> rtl/downsampling_convolution_extension_top.sv
// ----------------------------------------------------------------------------
// downsampling_convolution_extension_top
// Decimating convolution with signal extension for wavelet analysis.
//
//  port      dir  payload                          transfer
//  i_in      in   func, value[15:0], last          valid & ready
//  o_out     out  coefficient[47:0], last_result   valid & ready
//  i_cfg_*   in   idx[1:0], wdata[4:0]             i_cfg_we
//
// Taps and samples are taken one per cycle while idle. The sample with last
// starts a run: an edge step fetches the edge samples, an init step walks to
// the first output i0 (F/2 for periodization, step - 1 otherwise), then
// each result takes a check step, issue steps with one tap read per cycle,
// a multiply-accumulate drain and the emit step.
// Input is blocked for the whole run. A stalled result holds the run at emit.
// Reset is synchronous, active low; memories are not cleared.
// ----------------------------------------------------------------------------
module downsampling_convolution_extension_top import dce_pkg::*; #(
    parameter int MAX_TAPS    = 16,
    parameter int MAX_SAMPLES = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dce_in_if.sink                i_in,
    dce_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "assert_macros.svh"

    localparam int TA    = $clog2(MAX_TAPS);
    localparam int SA    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int FW    = $clog2(MAX_TAPS + 1);
    localparam int KW    = $clog2(MAX_TAPS);
    localparam int LW    = $clog2(2 * MAX_SAMPLES + 1);
    localparam int POS_W = $clog2(MAX_SAMPLES + MAX_TAPS + 1) + 2;

    t_state r_state, n_state;

    // Configuration
    logic [MODE_W-1:0]   r_mode;
    logic [STEP_W-1:0]   r_step;
    logic [TAPCNT_W-1:0] r_tapcnt;

    // Load pointers
    logic [TA-1:0] r_tap_ptr, n_tap_ptr;
    logic [CW-1:0] r_count, n_count;

    // Run parameters
    logic [CW-1:0]           r_n, n_n;
    logic [MODE_W-1:0]       r_emode;
    logic [FW-1:0]           r_f;
    logic [STEP_W-1:0]       r_stp;
    logic [LW-1:0]           r_len;
    logic signed [POS_W-1:0] r_end, r_i0;

    // Run position
    logic signed [POS_W-1:0] r_i, n_i, r_p, n_p;
    logic [LW-1:0]           r_qi, n_qi, r_q, n_q;
    logic [FW-1:0]           r_j, n_j;
    logic [2:0]              r_ec, n_ec;

    // Edge samples
    logic signed [SAMPLE_BITS-1:0] r_s0, r_s1, r_sn1, r_sn2;

    // Result register
    logic                    r_out_valid, n_out_valid;
    logic signed [ACC_W-1:0] r_out_coef;
    logic                    r_out_last;

    // Store and MAC connections
    logic                          w_tap_we, w_smp_we;
    logic [SA-1:0]                 w_smp_raddr;
    logic signed [VALUE_W-1:0]     w_tap_rdata;
    logic signed [SAMPLE_BITS-1:0] w_smp_rdata;
    t_issue                        w_issue;
    logic [KW-1:0]                 w_k;
    logic                          w_busy;
    logic signed [ACC_W-1:0]       w_acc;

    logic                    w_in_acc, w_out_acc, w_room, w_load;
    logic [CW-1:0]           w_count_inc;
    logic signed [POS_W-1:0] w_n_pos, w_fh, w_end, w_i0, w_p_lo;
    logic [FW-1:0]           w_f;
    logic [MODE_W-1:0]       w_emode;
    logic [LW-1:0]           w_len, w_qsum;
    logic [STEP_W-1:0]       w_stp;
    logic                    w_in_rng, w_done, w_last;
    t_ext_sel                w_sel;
    logic [SA-1:0]           w_addr;

    assign w_in_acc  = i_in.valid & i_in.ready;
    assign w_out_acc = o_out.valid & o_out.ready;
    assign w_room    = (r_count < CW'(MAX_SAMPLES));
    assign w_count_inc = w_room ? r_count + 1'b1 : r_count;
    assign w_n_pos   = signed'(POS_W'(r_n));

    // Run parameters from configuration and sample count
    always_comb begin
        w_f = (32'(r_tapcnt) > 32'(MAX_TAPS)) ? FW'(MAX_TAPS) : FW'(r_tapcnt);
        w_stp = (r_step == '0) ? STEP_W'(1) : r_step;
        if (r_mode == MODE_LINEXT && r_n < CW'(2)) begin
            w_emode = MODE_CONST;
        end else if (r_mode > MODE_PERZ) begin
            w_emode = MODE_ZERO;
        end else begin
            w_emode = r_mode;
        end
        case (w_emode)
            MODE_PER:  w_len = LW'(r_n);
            MODE_PERZ: w_len = LW'(r_n) + LW'(r_n[0]);
            default:   w_len = LW'({r_n, 1'b0});
        endcase
        w_fh = signed'(POS_W'(w_f >> 1));
        if (w_emode == MODE_PERZ) begin
            w_end = w_n_pos + w_fh;
            w_i0  = w_fh;
        end else begin
            w_end = w_n_pos + signed'(POS_W'(w_f)) - POS_W'(1);
            w_i0  = signed'(POS_W'(w_stp)) - POS_W'(1);
        end
    end

    // Extended sample source for position r_p
    always_comb begin
        w_in_rng = (r_p >= 0) && (r_p < w_n_pos);
        w_p_lo   = -r_p;
        w_sel    = SEL_MEM;
        w_addr   = SA'(r_p);
        w_k      = '0;
        if (!w_in_rng) begin
            case (r_emode)
                MODE_SYM: begin
                    w_addr = (r_q < LW'(r_n)) ? SA'(r_q)
                                              : SA'(LW'({r_n, 1'b0}) - LW'(1) - r_q);
                end
                MODE_CONST: begin
                    w_sel = (r_p < 0) ? SEL_LEFT : SEL_RIGHT;
                end
                MODE_LINEXT: begin
                    if (r_p < 0) begin
                        w_sel = SEL_SML;
                        w_k   = KW'(w_p_lo);
                    end else begin
                        w_sel = SEL_SMR;
                        w_k   = KW'(r_p - w_n_pos + POS_W'(1));
                    end
                end
                MODE_PER: begin
                    w_addr = SA'(r_q);
                end
                MODE_PERZ: begin
                    w_addr = (r_q < LW'(r_n)) ? SA'(r_q) : SA'(r_n - 1'b1);
                end
                default: begin
                    w_sel = SEL_ZERO;
                end
            endcase
        end
    end

    assign w_done = (r_i >= r_end);
    assign w_last = ((r_i + signed'(POS_W'(r_stp))) >= r_end);
    assign w_load = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in.func == FUNC_SAMPLE && i_in.last) begin
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: begin
                if (r_ec == 3'd4) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                if (r_i == r_i0) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK:  n_state = w_done ? ST_FINISH : ST_ISSUE;
            ST_ISSUE: begin
                if (r_j == r_f) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb begin
        n_tap_ptr   = r_tap_ptr;
        n_count     = r_count;
        n_n         = r_n;
        n_i         = r_i;
        n_qi        = r_qi;
        n_p         = r_p;
        n_q         = r_q;
        n_j         = r_j;
        n_ec        = r_ec;
        n_out_valid = r_out_valid & ~w_out_acc;
        w_tap_we    = 1'b0;
        w_smp_we    = 1'b0;
        w_smp_raddr = w_addr;
        w_issue     = '{valid: 1'b0, clr: 1'b0, sel: w_sel};
        w_qsum      = r_qi + LW'(r_stp);
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == FUNC_TAP) begin
                        w_tap_we  = 1'b1;
                        n_tap_ptr = (r_tap_ptr == TA'(MAX_TAPS - 1)) ? '0
                                                                      : r_tap_ptr + 1'b1;
                    end else begin
                        w_smp_we = w_room;
                        n_count  = w_count_inc;
                        n_n      = w_count_inc;
                        n_ec     = '0;
                    end
                end
            end
            ST_EDGE: begin
                case (r_ec)
                    3'd0:    w_smp_raddr = '0;
                    3'd1:    w_smp_raddr = SA'(1);
                    3'd2:    w_smp_raddr = SA'(r_n - 1'b1);
                    default: w_smp_raddr = SA'(r_n - 2'd2);
                endcase
                n_ec = r_ec + 1'b1;
                n_i  = '0;
                n_qi = '0;
            end
            ST_INIT: begin
                if (r_i != r_i0) begin
                    n_i  = r_i + POS_W'(1);
                    n_qi = (r_qi + LW'(1) >= r_len) ? '0 : r_qi + LW'(1);
                end
            end
            ST_CHECK: begin
                n_p = r_p;
                n_p = r_i;
                n_q = r_qi;
                n_j = '0;
                w_issue.clr = ~w_done;
            end
            ST_ISSUE: begin
                if (r_j != r_f) begin
                    w_issue.valid = 1'b1;
                    n_j = r_j + 1'b1;
                    n_p = r_p - POS_W'(1);
                    n_q = (r_q == '0) ? r_len - LW'(1) : r_q - LW'(1);
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_i = r_i + signed'(POS_W'(r_stp));
                    // step of up to 3 over a period as short as 1
                    if (w_qsum >= r_len) begin
                        w_qsum = w_qsum - r_len;
                    end
                    if (w_qsum >= r_len) begin
                        w_qsum = w_qsum - r_len;
                    end
                    if (w_qsum >= r_len) begin
                        w_qsum = w_qsum - r_len;
                    end
                    n_qi = w_qsum;
                end
            end
            ST_FINISH: begin
                n_count   = '0;
                n_tap_ptr = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_ZERO;
            r_step      <= STEP_W'(2);
            r_tapcnt    <= TAPCNT_W'(2);
            r_tap_ptr   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ec        <= '0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_tap_ptr   <= n_tap_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_ec        <= n_ec;
            r_j         <= n_j;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: r_mode   <= i_cfg_wdata[MODE_W-1:0];
                    REG_STEP: r_step   <= i_cfg_wdata[STEP_W-1:0];
                    REG_TAPS: r_tapcnt <= i_cfg_wdata[TAPCNT_W-1:0];
                    default:  r_mode   <= r_mode;
                endcase
            end
        end
    end

    // Run payload registers
    always_ff @(posedge i_clk) begin
        r_n  <= n_n;
        r_i  <= n_i;
        r_qi <= n_qi;
        r_p  <= n_p;
        r_q  <= n_q;
        if (r_state == ST_EDGE) begin
            r_emode <= w_emode;
            r_f     <= w_f;
            r_stp   <= w_stp;
            r_len   <= w_len;
            r_end   <= w_end;
            r_i0    <= w_i0;
            case (r_ec)
                3'd1:    r_s0  <= w_smp_rdata;
                3'd2:    r_s1  <= w_smp_rdata;
                3'd3:    r_sn1 <= w_smp_rdata;
                3'd4:    r_sn2 <= w_smp_rdata;
                default: r_s0  <= r_s0;
            endcase
        end
        if (w_load) begin
            r_out_coef <= w_acc;
            r_out_last <= w_last;
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.coefficient = r_out_coef;
    assign o_out.last_result = r_out_last;

    dce_store #(
        .MAX_TAPS    (MAX_TAPS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_tap_we    (w_tap_we),
        .i_tap_waddr (r_tap_ptr),
        .i_tap_wdata (i_in.value),
        .i_tap_raddr (r_j[TA-1:0]),
        .o_tap_rdata (w_tap_rdata),
        .i_smp_we    (w_smp_we),
        .i_smp_waddr (r_count[SA-1:0]),
        .i_smp_wdata (SAMPLE_BITS'(unsigned'(i_in.value))),
        .i_smp_raddr (w_smp_raddr),
        .o_smp_rdata (w_smp_rdata)
    );

    dce_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_k         (w_k),
        .i_tap_rdata (w_tap_rdata),
        .i_smp_rdata (w_smp_rdata),
        .i_s0        (r_s0),
        .i_s1        (r_s1),
        .i_sn1       (r_sn1),
        .i_sn2       (r_sn2),
        .o_busy      (w_busy),
        .o_acc       (w_acc)
    );

    // Checks
    `ASSERT_IMPL(a_no_input_while_busy, w_in_acc, !w_busy, "input taken during MAC activity")
    `ASSERT_IMPL(a_emit_after_drain, w_load, !w_busy, "result loaded before MAC drained")
    `ASSERT_IMPL(a_tap_in_range, w_issue.valid, r_j < r_f, "tap index beyond tap count")
    `ASSERT_NEXT(a_finish_clears, r_state == ST_FINISH, r_count == '0 && r_tap_ptr == '0,
        "load pointers not cleared after run")

endmodule

>>> rtl/dce_store.sv
// ----------------------------------------------------------------------------
// dce_store
// Tap and sample memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module dce_store import dce_pkg::*; #(
    parameter int MAX_TAPS    = 16,
    parameter int MAX_SAMPLES = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_tap_we,
    input  logic [$clog2(MAX_TAPS)-1:0]          i_tap_waddr,
    input  logic signed [VALUE_W-1:0]            i_tap_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]          i_tap_raddr,
    output logic signed [VALUE_W-1:0]            o_tap_rdata,
    input  logic                                 i_smp_we,
    input  logic [$clog2(MAX_SAMPLES)-1:0]       i_smp_waddr,
    input  logic signed [SAMPLE_BITS-1:0]        i_smp_wdata,
    input  logic [$clog2(MAX_SAMPLES)-1:0]       i_smp_raddr,
    output logic signed [SAMPLE_BITS-1:0]        o_smp_rdata
);

    logic signed [VALUE_W-1:0]     r_tap_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_smp_mem [MAX_SAMPLES];

    // Tap memory
    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_waddr] <= i_tap_wdata;
        end
        o_tap_rdata <= r_tap_mem[i_tap_raddr];
    end

    // Sample memory
    always_ff @(posedge i_clk) begin
        if (i_smp_we) begin
            r_smp_mem[i_smp_waddr] <= i_smp_wdata;
        end
        o_smp_rdata <= r_smp_mem[i_smp_raddr];
    end

endmodule

>>> rtl/dce_mac.sv
// ----------------------------------------------------------------------------
// dce_mac
// Extension value build, tap multiply and saturating 48-bit accumulate.
// ----------------------------------------------------------------------------
module dce_mac import dce_pkg::*; #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_issue                            i_issue,
    input  logic [$clog2(MAX_TAPS)-1:0]       i_k,
    input  logic signed [VALUE_W-1:0]         i_tap_rdata,
    input  logic signed [SAMPLE_BITS-1:0]     i_smp_rdata,
    input  logic signed [SAMPLE_BITS-1:0]     i_s0,
    input  logic signed [SAMPLE_BITS-1:0]     i_s1,
    input  logic signed [SAMPLE_BITS-1:0]     i_sn1,
    input  logic signed [SAMPLE_BITS-1:0]     i_sn2,
    output logic                              o_busy,
    output logic signed [ACC_W-1:0]           o_acc
);

    localparam int KW    = $clog2(MAX_TAPS);
    localparam int EXTW  = SAMPLE_BITS + KW + 2;
    localparam int PRODW = VALUE_W + EXTW;
    localparam int SUMW  = ((PRODW > ACC_W) ? PRODW : ACC_W) + 1;

    logic                      r_v0, r_v1, r_v2;
    t_ext_sel                  r_sel0;
    logic [KW-1:0]             r_k0;
    logic signed [VALUE_W-1:0] r_tap1;
    logic signed [EXTW-1:0]    r_ext1;
    logic signed [PRODW-1:0]   r_prod2;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [EXTW-1:0]    w_base, w_diff, w_kx, w_ext;
    logic signed [SUMW-1:0]    w_sum;
    logic signed [ACC_W-1:0]   n_acc;

    // Extended sample: zero, memory data, edge value, or linear extrapolation
    always_comb begin
        w_base = '0;
        w_diff = '0;
        case (r_sel0)
            SEL_MEM:   w_base = EXTW'(i_smp_rdata);
            SEL_LEFT:  w_base = EXTW'(i_s0);
            SEL_RIGHT: w_base = EXTW'(i_sn1);
            SEL_SML: begin
                w_base = EXTW'(i_s0);
                w_diff = EXTW'(i_s0) - EXTW'(i_s1);
            end
            SEL_SMR: begin
                w_base = EXTW'(i_sn1);
                w_diff = EXTW'(i_sn1) - EXTW'(i_sn2);
            end
            default: w_base = '0;
        endcase
        w_kx  = EXTW'(signed'({1'b0, r_k0})) * w_diff;
        w_ext = w_base + w_kx;
    end

    // Saturating accumulate
    always_comb begin
        w_sum = SUMW'(r_acc) + SUMW'(r_prod2);
        if (w_sum > SUMW'(ACC_MAX)) begin
            n_acc = ACC_MAX;
        end else if (w_sum < SUMW'(ACC_MIN)) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = ACC_W'(w_sum);
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_issue.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Stage payload and accumulator
    always_ff @(posedge i_clk) begin
        r_sel0  <= i_issue.sel;
        r_k0    <= i_k;
        r_tap1  <= i_tap_rdata;
        r_ext1  <= w_ext;
        r_prod2 <= PRODW'(r_tap1) * PRODW'(r_ext1);
        if (i_issue.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    assign o_busy = i_issue.valid | r_v0 | r_v1 | r_v2;
    assign o_acc  = r_acc;

endmodule

>>> tb/sv/downsampling_convolution_extension_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downsampling_convolution_extension_top_tb
// Self-checking bench for the decimating convolution with signal extension.
// A directed table loads taps and short signals with hand-computed sums.
// Random phases then sweep every mode and step and random tap counts, including
// the unused codes, with random idle cycles on input and backpressure on output.
// Every result is checked against a local model of the filter.
// ----------------------------------------------------------------------------
module downsampling_convolution_extension_top_tb;
    import dce_pkg::*;

    localparam int NTAPS   = 16;
    localparam int NSAMP   = 32;
    localparam int WD_LIMIT = 5000;
    localparam int SETTLE  = 100;
    localparam int N_ITEMS = 380;

    typedef struct {
        logic             func;
        logic signed [15:0] value;
        logic             last;
        bit               typed;
        longint           sum;
    } t_row;

    typedef struct {
        logic signed [ACC_W-1:0] coef;
        logic                    last;
    } t_coef;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    dce_in_if  in_ch ();
    dce_out_if out_ch ();

    downsampling_convolution_extension_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Filter model state
    logic [MODE_W-1:0]   ext_mode;
    logic [STEP_W-1:0]   dec_step;
    logic [TAPCNT_W-1:0] ntap_cfg;
    longint              taps [NTAPS];
    longint              samples [NSAMP];
    int                  n_samples;
    int                  tap_ptr;

    t_coef coef_q [$];
    int    errors;
    int    items_sent;
    int    coefs_seen;
    int    runs_done;
    int    idle_cnt;
    bit    no_idle;
    bit    done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint exp_v);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp_v,
                 coefs_seen);
    endtask

    // Sample at position p, extended past the edges
    function automatic longint ext_sample(longint p, longint n, logic [MODE_W-1:0] m);
        longint len;
        longint q;
        if (p >= 0 && p < n) return samples[p];
        if (m == MODE_LINEXT && n < 2) m = MODE_CONST;
        case (m)
            MODE_SYM: begin
                len = 2 * n;
                q = p % len;
                if (q < 0) q += len;
                return (q < n) ? samples[q] : samples[len - 1 - q];
            end
            MODE_CONST: return (p < 0) ? samples[0] : samples[n - 1];
            MODE_LINEXT: begin
                if (p < 0) return samples[0] + (-p) * (samples[0] - samples[1]);
                return samples[n - 1] + (p - n + 1) * (samples[n - 1] - samples[n - 2]);
            end
            MODE_PER: begin
                q = p % n;
                if (q < 0) q += n;
                return samples[q];
            end
            MODE_PERZ: begin
                len = n + (n & 1);
                q = p % len;
                if (q < 0) q += len;
                return (q < n) ? samples[q] : samples[n - 1];
            end
            default: return 0;
        endcase
    endfunction

    // Updates the model with one accepted item, returns number of results queued
    function automatic int predict_item(logic func, logic signed [15:0] value, logic last);
        longint n, f, stp, i, stop, acc;
        t_coef  r;
        int     cnt;
        cnt = 0;
        if (func == FUNC_TAP) begin
            taps[tap_ptr] = value;
            tap_ptr = (tap_ptr + 1) % NTAPS;
            return 0;
        end
        if (n_samples < NSAMP) begin
            samples[n_samples] = value;
            n_samples++;
        end
        if (!last) return 0;
        n   = n_samples;
        f   = (ntap_cfg > NTAPS) ? NTAPS : ntap_cfg;
        stp = (dec_step == 0) ? 1 : dec_step;
        if (ext_mode == MODE_PERZ) begin
            i = f / 2;
            stop = n + f / 2;
        end else begin
            i = stp - 1;
            stop = n + f - 1;
        end
        for (; i < stop; i += stp) begin
            acc = 0;
            for (longint j = 0; j < f; j++) begin
                acc += taps[j] * ext_sample(i - j, n, ext_mode);
                if (acc > longint'(ACC_MAX)) acc = ACC_MAX;
                if (acc < longint'(ACC_MIN)) acc = ACC_MIN;
            end
            r.coef = acc[ACC_W-1:0];
            r.last = 1'b0;
            coef_q.push_back(r);
            cnt++;
        end
        if (cnt > 0) coef_q[$].last = 1'b1;
        n_samples = 0;
        tap_ptr = 0;
        runs_done++;
        return cnt;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE: ext_mode = d[MODE_W-1:0];
            REG_STEP: dec_step = d[STEP_W-1:0];
            REG_TAPS: ntap_cfg = d[TAPCNT_W-1:0];
            default: ;
        endcase
    endtask

    // Drives one item and waits for its transaction
    task automatic send_item(input logic func, input logic signed [15:0] value,
                             input logic last, output int nres);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.func  = func;
        in_ch.value = value;
        in_ch.last  = last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        nres = predict_item(func, value, last);
        items_sent++;
    endtask

    // Lets the block go quiet before touching its registers
    task automatic drain_quiet();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (coef_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 7)) - 3);
            default: return 16'($urandom());
        endcase
    endfunction

    // Result side: random backpressure and checking
    initial begin
        int     stall;
        t_coef  e;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            coefs_seen++;
            if (coef_q.size() == 0) begin
                report("unexpected result", out_ch.coefficient, 0);
            end else begin
                e = coef_q.pop_front();
                if (out_ch.coefficient !== e.coef)
                    report("coefficient", out_ch.coefficient, e.coef);
                if (out_ch.last_result !== e.last)
                    report("last_result", out_ch.last_result, e.last);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", coef_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_row rows [$];
        t_row row;
        int   nres;
        int   ph;
        int   ntw;
        int   len;
        logic [TAPCNT_W-1:0] tap_sweep [8];
        tap_sweep = '{5'd16, 5'd2, 5'd0, 5'd17, 5'd31, 5'd9, 5'd1, 5'd16};

        errors = 0; items_sent = 0; coefs_seen = 0; runs_done = 0;
        no_idle = 1'b0; done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        in_ch.valid = 1'b0; in_ch.func = FUNC_TAP; in_ch.value = '0; in_ch.last = 1'b0;
        ext_mode = MODE_ZERO; dec_step = 2'd2; ntap_cfg = 5'd2;
        n_samples = 0; tap_ptr = 0;
        foreach (taps[k]) taps[k] = 0;
        foreach (samples[k]) samples[k] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table under reset configuration: zero padding, step 2, two taps
        rows.push_back('{FUNC_TAP, 16'sh7FFF, 1'b0, 1'b0, 0});
        rows.push_back('{FUNC_TAP, 16'sh8000, 1'b0, 1'b0, 0});
        for (int k = 2; k < NTAPS; k++)
            rows.push_back('{FUNC_TAP, 16'(k[0] ? 16'h5555 : 16'hAAAA), 1'b0, 1'b0, 0});
        rows.push_back('{FUNC_SAMPLE, 16'sh7FFF, 1'b0, 1'b0, 0});
        rows.push_back('{FUNC_SAMPLE, 16'sh8000, 1'b1, 1'b1, -64'sd2147418112});
        // one-sample signal
        rows.push_back('{FUNC_SAMPLE, 16'sd1, 1'b1, 1'b1, -64'sd32768});
        // last on a tap is ignored; tap 0 gets replaced
        rows.push_back('{FUNC_TAP, 16'sd12345, 1'b1, 1'b0, 0});
        rows.push_back('{FUNC_SAMPLE, 16'sd0, 1'b0, 1'b0, 0});
        rows.push_back('{FUNC_SAMPLE, -16'sd1, 1'b1, 1'b1, -64'sd12345});
        foreach (rows[k]) begin
            row = rows[k];
            send_item(row.func, row.value, row.last, nres);
            if (row.typed && (nres != 1 || longint'(coef_q[$].coef) != row.sum
                              || coef_q[$].last !== 1'b1))
                report("directed row", longint'(coef_q[$].coef), row.sum);
        end
        drain_quiet();

        // Random phases; the first eight sweep every code and the extremes
        ph = 0;
        while (items_sent < N_ITEMS) begin
            if (ph < 8) begin
                cfg_write(REG_MODE, CFG_DATA_W'(ph));
                cfg_write(REG_STEP, CFG_DATA_W'(ph % 4));
                cfg_write(REG_TAPS, tap_sweep[ph]);
            end else begin
                cfg_write(REG_MODE, CFG_DATA_W'($urandom_range(0, 7)));
                cfg_write(REG_STEP, CFG_DATA_W'($urandom_range(0, 3)));
                cfg_write(REG_TAPS, CFG_DATA_W'($urandom_range(0, 31)));
            end
            no_idle = (ph % 5 == 4);
            repeat (2) begin
                // fresh taps, now and then enough to wrap the pointer
                ntw = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 3);
                repeat (ntw)
                    send_item(FUNC_TAP, rand_value(), 1'($urandom_range(0, 1)), nres);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                                  : $urandom_range(1, 8);
                for (int k = 1; k <= len; k++)
                    send_item(FUNC_SAMPLE, rand_value(), k == len, nres);
            end
            drain_quiet();
            ph++;
        end

        done = 1'b1;
        $display("Covered %0d items, %0d runs, %0d results over %0d register phases",
                 items_sent, runs_done, coefs_seen, ph);
        $display("Extension modes 0-7, steps 0-3, tap counts 0-31 with wrap and overflow");
        if (errors == 0 && coef_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d results missing", errors, coef_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
